// File: rtl/stt_pkg.sv
package stt_pkg;

    localparam int TIMER_SLOTS_DEF = 16;
    localparam int TAG_BITS_DEF    = 16;

    // Action codes
    localparam logic [3:0] ACT_CREATE    = 4'd0;
    localparam logic [3:0] ACT_CREATE_ID = 4'd1;
    localparam logic [3:0] ACT_TICK      = 4'd2;
    localparam logic [3:0] ACT_CHECK     = 4'd3;
    localparam logic [3:0] ACT_FINISH    = 4'd4;
    localparam logic [3:0] ACT_SET_LIMIT = 4'd5;
    localparam logic [3:0] ACT_RESTART   = 4'd6;
    localparam logic [3:0] ACT_EXPIRE    = 4'd7;
    localparam logic [3:0] ACT_QUERY     = 4'd8;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_REJECTED  = 2'd3;

    typedef struct packed {
        logic [3:0]  action;
        logic [15:0] timer_tag;
        logic [30:0] time_value;
        logic        loop_mode;
        logic        start_expired;
    } stt_cmd_t;

    typedef struct packed {
        logic        flag;
        logic [1:0]  status;
        logic [15:0] given_tag;
    } stt_rsp_t;

    // Timer body as kept in the slot memory (tag stored alongside)
    typedef struct packed {
        logic [31:0] elapsed;
        logic [30:0] limit;
        logic        loop;
        logic        finished;
    } stt_timer_t;

    localparam int TIMER_W = $bits(stt_timer_t);

    typedef struct packed {
        logic       match;
        logic       keep;
        logic       flag;
        stt_timer_t timer;
    } stt_alu_res_t;

endpackage

// File: rtl/stt_slot_alu.sv
module stt_slot_alu #(
    parameter int TAG_BITS = stt_pkg::TAG_BITS_DEF
) (
    input  logic [3:0]            action,
    input  logic [30:0]           amount,
    input  logic [TAG_BITS-1:0]   key_tag,
    input  logic [TAG_BITS-1:0]   slot_tag,
    input  stt_pkg::stt_timer_t   timer,
    output stt_pkg::stt_alu_res_t res
);
    import stt_pkg::*;

    logic [32:0] sum;

    assign sum = {1'b0, timer.elapsed} + {2'b00, amount};

    always_comb
    begin
        res       = '0;
        res.timer = timer;
        res.match = (slot_tag == key_tag);
        res.keep  = !timer.finished;
        case (action)
            ACT_TICK:
            begin
                // saturate at all ones
                res.timer.elapsed = sum[32] ? '1 : sum[31:0];
            end
            ACT_CHECK:
            begin
                if (timer.elapsed > {1'b0, timer.limit})
                begin
                    res.flag = 1'b1;
                    if (timer.loop)
                        res.timer.elapsed = '0;
                    else
                        res.timer.finished = 1'b1;
                end
            end
            ACT_FINISH:    res.timer.finished = 1'b1;
            ACT_SET_LIMIT: res.timer.limit = amount;
            ACT_RESTART:   res.timer.elapsed = '0;
            ACT_EXPIRE:    res.timer.elapsed = {1'b0, timer.limit} + 32'd1;
            ACT_QUERY:     res.flag = 1'b1;
            default:       res.flag = 1'b0;
        endcase
    end

endmodule

// File: rtl/software_timer_table_top.sv
// Table of tagged software timers, kept packed in creation order.
// Command channel (cmd_valid/cmd_stall/cmd_word) carries one action word;
// response channel (rsp_valid/rsp_stall/rsp_word) returns exactly one word
// per command: flag, status and the tag given by a create.
// A word moves at a clock edge where valid is high and stall is low.
// Creates and unused action codes post their response word through the
// pending register and then the output register. Tick and the tag lookups
// (check, finish, set limit, restart, expire next, query) walk the slot
// memory one slot per cycle through a single shared slot ALU, and a lookup
// stops at the first matching slot; the slot memory has a single read port.
// cmd_stall stays high for the whole command.
// Tick compacts the table in the same pass, writing kept slots downward.
// Reset (rst_n low, asynchronous) empties the table and zeros the next tag;
// no clearing pass is needed since only slots below the count are read.
// A stalled response word holds in the output register; the next command
// may be taken meanwhile and its result waits until the register frees.
module software_timer_table_top #(
    parameter int TIMER_SLOTS = stt_pkg::TIMER_SLOTS_DEF,
    parameter int TAG_BITS    = stt_pkg::TAG_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  stt_pkg::stt_cmd_t cmd_word,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output stt_pkg::stt_rsp_t rsp_word
);
    import stt_pkg::*;

    localparam int IDX_W   = $clog2(TIMER_SLOTS);
    localparam int CNT_W   = $clog2(TIMER_SLOTS + 1);
    localparam int ENTRY_W = TAG_BITS + TIMER_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_POST = 2'd2;

    // control state
    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TAG_BITS-1:0] next_tag_reg, next_tag_next;
    logic [CNT_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [CNT_W-1:0]    w_ptr_reg, w_ptr_next;
    logic                rsp_valid_reg, rsp_valid_next;

    // payload
    logic [3:0]          act_reg;
    logic [TAG_BITS-1:0] key_reg;
    logic [30:0]         amount_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [ENTRY_W-1:0]  rd_data_reg;
    stt_rsp_t            pend_reg, pend_next;
    stt_rsp_t            rsp_word_reg, rsp_word_next;
    logic                load_item;

    // slot memory
    logic [ENTRY_W-1:0]  slot_mem [TIMER_SLOTS];
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic [IDX_W-1:0]    rd_addr;

    // create path
    logic [TAG_BITS-1:0] cmd_key;
    logic [TAG_BITS-1:0] new_tag;
    logic                table_full;
    logic                tag_reject;
    stt_timer_t          new_timer;

    // shared slot ALU
    logic [TAG_BITS-1:0] slot_tag;
    stt_timer_t          slot_timer;
    stt_alu_res_t        alu_res;

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    assign cmd_key    = TAG_BITS'(cmd_word.timer_tag);
    assign table_full = (count_reg == CNT_W'(TIMER_SLOTS));
    assign tag_reject = (cmd_word.action == ACT_CREATE_ID) && (cmd_key > next_tag_reg);
    assign new_tag    = (cmd_word.action == ACT_CREATE) ? next_tag_reg : cmd_key;

    always_comb
    begin
        new_timer          = '0;
        new_timer.limit    = cmd_word.time_value;
        new_timer.loop     = cmd_word.loop_mode;
        new_timer.elapsed  = cmd_word.start_expired ?
                             ({1'b0, cmd_word.time_value} + 32'd1) : 32'd0;
    end

    assign slot_tag   = rd_data_reg[ENTRY_W-1 -: TAG_BITS];
    assign slot_timer = stt_timer_t'(rd_data_reg[TIMER_W-1:0]);

    stt_slot_alu #(
        .TAG_BITS (TAG_BITS)
    ) u_alu (
        .action   (act_reg),
        .amount   (amount_reg),
        .key_tag  (key_reg),
        .slot_tag (slot_tag),
        .timer    (slot_timer),
        .res      (alu_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        next_tag_next  = next_tag_reg;
        rd_ptr_next    = rd_ptr_reg;
        rd_vld_next    = 1'b0;
        w_ptr_next     = w_ptr_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_word_next  = rsp_word_reg;
        pend_next      = pend_reg;
        load_item      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        rd_addr        = rd_ptr_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    load_item  = 1'b1;
                    pend_next  = '0;
                    state_next = S_POST;
                    if (cmd_word.action == ACT_CREATE || cmd_word.action == ACT_CREATE_ID)
                    begin
                        if (table_full)
                            pend_next.status = ST_FULL;
                        else if (tag_reject)
                            pend_next.status = ST_REJECTED;
                        else
                        begin
                            // append at the end of the packed table
                            mem_we              = 1'b1;
                            mem_waddr           = count_reg[IDX_W-1:0];
                            mem_wdata           = {new_tag, new_timer};
                            count_next          = count_reg + 1'b1;
                            next_tag_next       = new_tag + 1'b1;
                            pend_next.flag      = 1'b1;
                            pend_next.given_tag = 16'(new_tag);
                        end
                    end
                    else if (cmd_word.action inside {[ACT_TICK:ACT_QUERY]})
                    begin
                        rd_ptr_next = '0;
                        w_ptr_next  = '0;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // issue one slot read per cycle
                if (rd_ptr_reg < count_reg)
                begin
                    rd_vld_next = 1'b1;
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    if (act_reg == ACT_TICK)
                    begin
                        // keep unfinished timers, packed down to w_ptr
                        if (alu_res.keep)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = w_ptr_reg[IDX_W-1:0];
                            mem_wdata  = {slot_tag, alu_res.timer};
                            w_ptr_next = w_ptr_reg + 1'b1;
                        end
                    end
                    else if (alu_res.match)
                    begin
                        mem_we         = 1'b1;
                        mem_waddr      = rd_idx_reg;
                        mem_wdata      = {slot_tag, alu_res.timer};
                        pend_next.flag = alu_res.flag;
                        rd_vld_next    = 1'b0;
                        state_next     = S_POST;
                    end
                end
                else if (rd_ptr_reg >= count_reg)
                begin
                    // pass complete, nothing in flight
                    if (act_reg == ACT_TICK)
                        count_next = w_ptr_reg;
                    else
                        pend_next.status = ST_NOT_FOUND;
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_word_next  = pend_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            next_tag_reg  <= '0;
            rd_ptr_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            w_ptr_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            next_tag_reg  <= next_tag_next;
            rd_ptr_reg    <= rd_ptr_next;
            rd_vld_reg    <= rd_vld_next;
            w_ptr_reg     <= w_ptr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_item)
        begin
            act_reg    <= cmd_word.action;
            key_reg    <= cmd_key;
            amount_reg <= cmd_word.time_value;
        end
        pend_reg     <= pend_next;
        rsp_word_reg <= rsp_word_next;
    end

    // slot memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            slot_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= slot_mem[rd_addr];
        rd_idx_reg  <= rd_addr;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TIMER_SLOTS))
        else $error("slot count above table size");

    a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> w_ptr_reg <= rd_ptr_reg)
        else $error("compaction write pointer overtook read pointer");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> state_reg == S_SCAN)
        else $error("slot read data pending outside scan");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("command taken without going busy");
`endif

endmodule
